@@ rtl/slabpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slabpg_pkg
// Shared types and constants for the slab page bitmap allocator.
// ----------------------------------------------------------------------------
package slabpg_pkg;

  localparam int OFFSET_LIMIT = 4096;
  localparam int OFF_W        = $clog2(OFFSET_LIMIT);  // offset bits checked by a free
  localparam int SIZE_W       = 13;                     // page_length / object_size
  localparam int CNT_W        = 8;                      // object_count
  localparam int BASE_W       = 32;
  localparam int ROW_BITS     = 8;                      // bitmap bits per memory row
  localparam int BIT_W        = $clog2(ROW_BITS);
  localparam int CFG_IDX_W    = 2;

  localparam int DEF_MAX_SLOTS = 128;
  localparam int DEF_ADDR_BITS = 32;

  localparam logic [SIZE_W-1:0] RST_PAGE_LENGTH  = 13'd4096;
  localparam logic [SIZE_W-1:0] RST_OBJECT_SIZE  = 13'd32;
  localparam logic [CNT_W-1:0]  RST_OBJECT_COUNT = 8'hff & 8'd128;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_DOUBLE  = 2'd2,
    ST_BADADDR = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGE_BASE    = 2'd0,
    REG_PAGE_LENGTH  = 2'd1,
    REG_OBJECT_SIZE  = 2'd2,
    REG_OBJECT_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BM_QUERY = 2'd0,
    BM_ALLOC = 2'd1,
    BM_FREE  = 2'd2
  } bm_kind_t;

  typedef struct packed {
    logic     start;
    bm_kind_t kind;
  } bm_cmd_t;

  typedef struct packed {
    logic done;
    logic found;      // allocate found a free slot
    logic dbl;        // free hit a slot that was already free
    logic has_space;
    logic all_free;
  } bm_rsp_t;

endpackage

@@ rtl/slab_page_bitmap_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_page_bitmap_allocator
// One slab page of equal-size objects tracked by an occupancy bitmap.
// ----------------------------------------------------------------------------
// Input channel in_*: in_tuser carries the op (allocate, free, query), in_tdata
// the address to free. Output channel out_*: one result per request, with the
// allocated address in out_tdata and status plus space flags in out_tuser.
// The cfg_* port writes page_base, page_length, object_size, object_count;
// the user writes them only while the block is idle; the block does not enforce it.
// One request is in flight at a time. The bitmap lives in a memory of
// ROWS = MAX_SLOTS/8 rows, and every request scans all rows once, one row per
// cycle. A query passes through the check, scan and emit states; an allocate
// that finds a slot adds the address multiply and add states. A free that
// passes the range check runs the bit-serial offset / object_size divide before
// its scan. At the earliest, the next request is accepted in the cycle in which
// out_tvalid rises.
// Reset clears the control state and the per-row valid bits at once, so the
// whole bitmap reads as free on the next cycle; no clearing pass is needed.
// A result waits in the output register while out_tready is low; the next
// request is then taken but its result holds until the register empties.
// ----------------------------------------------------------------------------
module slab_page_bitmap_allocator
  import slabpg_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int ADDR_BITS = DEF_ADDR_BITS
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // [31:0] addr
  input  logic [1:0]           in_tuser,   // [1:0] op
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [31:0] alloc_addr
  output logic [3:0]           out_tuser,  // [1:0] status, [2] has_space, [3] all_free
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_wdata
);

  localparam int ROWS   = (MAX_SLOTS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = ROW_W + BIT_W;
  localparam int LIM_W  = SLOT_W + 1;
  localparam int PROD_W = SLOT_W + SIZE_W;
  localparam int CMP_W  = (LIM_W > OFF_W) ? ((LIM_W > CNT_W) ? LIM_W : CNT_W)
                                          : ((OFF_W > CNT_W) ? OFF_W : CNT_W);
  localparam logic [BASE_W-1:0] AMASK =
    (ADDR_BITS >= BASE_W) ? {BASE_W{1'b1}} : BASE_W'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [BASE_W-1:0] page_base_r;
  logic [SIZE_W-1:0] page_length_r;
  logic [SIZE_W-1:0] object_size_r;
  logic [CNT_W-1:0]  object_count_r;

  logic [1:0]        op_r;
  logic [31:0]       addr_r;
  status_t           status_r;
  logic [PROD_W-1:0] prod_r;
  logic [31:0]       res_addr_r;
  logic              has_space_r;
  logic              all_free_r;

  logic              out_valid_r;
  logic [31:0]       out_addr_r;
  status_t           out_status_r;
  logic              out_space_r;
  logic              out_free_r;

  logic [LIM_W-1:0]  limit;
  logic [BASE_W:0]   page_end;
  logic [BASE_W-1:0] offset;
  logic              addr_ok;

  logic              div_start;
  logic              div_done;
  logic [OFF_W-1:0]  div_q;
  logic [SIZE_W-1:0] div_rem;
  logic              slot_ok;

  bm_cmd_t           bm_cmd;
  bm_rsp_t           bm_rsp;
  logic [SLOT_W-1:0] bm_slot;

  logic              emit_go;
  logic              in_fire;

  assign limit = (CMP_W'(object_count_r) >= CMP_W'(MAX_SLOTS)) ? LIM_W'(MAX_SLOTS)
                                                                : LIM_W'(object_count_r);

  // address checks, all against the registered request
  assign page_end = {1'b0, page_base_r} + (BASE_W + 1)'(page_length_r);
  assign offset   = addr_r - page_base_r;
  assign addr_ok  = (addr_r >= page_base_r) && ((BASE_W + 1)'(addr_r) < page_end) &&
                    (object_size_r != '0) && (offset[BASE_W-1:OFF_W] == '0);

  assign slot_ok  = (div_rem == '0) && (CMP_W'(div_q) < CMP_W'(limit));

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign emit_go   = !out_valid_r || out_tready;
  assign div_start = (state_r == S_CHECK) && (op_r == OP_FREE) && addr_ok;

  always_comb begin
    bm_cmd.start = 1'b0;
    bm_cmd.kind  = BM_QUERY;
    if (state_r == S_CHECK) begin
      bm_cmd.start = (op_r != OP_FREE) || !addr_ok;
      if (op_r == OP_ALLOC) begin
        bm_cmd.kind = BM_ALLOC;
      end
    end else if (state_r == S_DIV && div_done) begin
      bm_cmd.start = 1'b1;
      bm_cmd.kind  = slot_ok ? BM_FREE : BM_QUERY;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_CHECK;
      S_CHECK: state_nxt = div_start ? S_DIV : S_SCAN;
      S_DIV:   if (div_done) state_nxt = S_SCAN;
      S_SCAN:  begin
        if (bm_rsp.done) begin
          state_nxt = (bm_rsp.found) ? S_MUL : S_EMIT;
        end
      end
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_EMIT;
      S_EMIT:  if (emit_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      page_base_r    <= '0;
      page_length_r  <= RST_PAGE_LENGTH;
      object_size_r  <= RST_OBJECT_SIZE;
      object_count_r <= RST_OBJECT_COUNT;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_PAGE_BASE:    page_base_r    <= cfg_wdata;
          REG_PAGE_LENGTH:  page_length_r  <= cfg_wdata[SIZE_W-1:0];
          REG_OBJECT_SIZE:  object_size_r  <= cfg_wdata[SIZE_W-1:0];
          REG_OBJECT_COUNT: object_count_r <= cfg_wdata[CNT_W-1:0];
          default:          page_base_r    <= page_base_r;
        endcase
      end
      if (state_r == S_EMIT && emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= in_tuser;
      addr_r     <= in_tdata;
      res_addr_r <= '0;
    end
    if (state_r == S_CHECK) begin
      status_r <= (op_r == OP_FREE && !addr_ok) ? ST_BADADDR : ST_OK;
    end
    if (state_r == S_DIV && div_done && !slot_ok) begin
      status_r <= ST_BADADDR;
    end
    if (state_r == S_SCAN && bm_rsp.done) begin
      has_space_r <= bm_rsp.has_space;
      all_free_r  <= bm_rsp.all_free;
      if (op_r == OP_ALLOC && !bm_rsp.found) begin
        status_r <= ST_NOSPACE;
      end else if (op_r == OP_FREE && status_r == ST_OK && bm_rsp.dbl) begin
        status_r <= ST_DOUBLE;
      end
    end
    if (state_r == S_MUL) begin
      prod_r <= bm_slot * object_size_r;
    end
    if (state_r == S_ADD) begin
      res_addr_r <= (page_base_r + BASE_W'(prod_r)) & AMASK;
    end
    if (state_r == S_EMIT && emit_go) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= status_r;
      out_space_r  <= has_space_r;
      out_free_r   <= all_free_r;
    end
  end

  slabpg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (offset[OFF_W-1:0]),
    .divisor  (object_size_r),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  slabpg_bitmap #(
    .MAX_SLOTS (MAX_SLOTS),
    .ROWS      (ROWS),
    .ROW_W     (ROW_W),
    .SLOT_W    (SLOT_W),
    .LIM_W     (LIM_W)
  ) u_bitmap (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (bm_cmd),
    .free_slot  (div_q[SLOT_W-1:0]),
    .limit      (limit),
    .rsp        (bm_rsp),
    .alloc_slot (bm_slot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = {out_free_r, out_space_r, out_status_r};

  // one request in flight: nothing is taken right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

  // a failed result carries a zero address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != ST_OK |-> out_tdata == '0)
    else $error("failed result with nonzero address");

  // no free slot implies no space flag
  a_nospace_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == ST_NOSPACE |-> !out_tuser[2] && out_tdata == '0)
    else $error("no-space result with space flag or address");

  // the bitmap only answers while a scan is pending
  a_bm_done_scan: assert property (@(posedge clk) disable iff (!rst_n)
    bm_rsp.done |-> state_r == S_SCAN)
    else $error("bitmap response outside of scan");

  // the divider only finishes for a free in progress
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV && op_r == OP_FREE)
    else $error("divider finished outside of a free");

endmodule

@@ rtl/slabpg_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slabpg_div
// Restoring divider, one quotient bit per cycle: page offset / object size.
// ----------------------------------------------------------------------------
module slabpg_div
  import slabpg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [OFF_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [OFF_W-1:0]  quot,
  output logic [SIZE_W-1:0] rem
);

  localparam int STEP_W = $clog2(OFF_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [OFF_W-1:0]  q_r;
  logic [SIZE_W-1:0] rem_r;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;
  logic              take;

  assign trial = {rem_r, q_r[OFF_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(OFF_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of q_r while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[OFF_W-2:0], take};
      rem_r <= take ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

@@ rtl/slabpg_bitmap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slabpg_bitmap
// Occupancy bitmap in a row memory; scans every row, then writes at most one row back.
// ----------------------------------------------------------------------------
module slabpg_bitmap
  import slabpg_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int ROWS      = (MAX_SLOTS + ROW_BITS - 1) / ROW_BITS,
  parameter int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1,
  parameter int SLOT_W    = ROW_W + BIT_W,
  parameter int LIM_W     = SLOT_W + 1
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  bm_cmd_t           cmd,
  input  logic [SLOT_W-1:0] free_slot,
  input  logic [LIM_W-1:0]  limit,
  output bm_rsp_t           rsp,
  output logic [SLOT_W-1:0] alloc_slot
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_FIN  = 3'b100
  } bm_state_t;

  bm_state_t state_r, state_nxt;

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROWS-1:0]     row_valid_r;

  logic [ROW_W:0]        issue_r;
  logic                  dv_r;
  logic [ROW_W-1:0]      drow_r;
  logic [ROW_BITS-1:0]   mem_q_r;
  logic                  vld_q_r;

  bm_kind_t              kind_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  ff_found_r;
  logic [SLOT_W-1:0]     ff_slot_r;
  logic [ROW_BITS-1:0]   ff_row_r;
  logic [ROW_BITS-1:0]   tgt_row_r;
  logic                  free2_r;
  logic                  used1_r;
  logic                  used2_r;

  logic [ROW_BITS-1:0]   row_bits;
  logic [ROW_BITS-1:0]   in_rng;
  logic [ROW_BITS-1:0]   free_m;
  logic [ROW_BITS-1:0]   used_m;
  logic [BIT_W-1:0]      low_pos;
  logic                  f1, f2, u1, u2;
  logic                  tgt_set;
  logic                  wr_en;
  logic [ROW_W-1:0]      wr_row;
  logic [ROW_BITS-1:0]   wr_data;

  // row data of a never-written row reads as all free
  always_comb begin
    row_bits = vld_q_r ? mem_q_r : '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      in_rng[j] = LIM_W'({drow_r, BIT_W'(j)}) < limit;
    end
    free_m  = ~row_bits & in_rng;
    used_m  = row_bits & in_rng;
    f1      = |free_m;
    f2      = |(free_m & (free_m - 1'b1));
    u1      = |used_m;
    u2      = |(used_m & (used_m - 1'b1));
    low_pos = '0;
    for (int j = ROW_BITS - 1; j >= 0; j--) begin
      if (free_m[j]) begin
        low_pos = BIT_W'(j);
      end
    end
  end

  assign tgt_set = tgt_row_r[slot_r[BIT_W-1:0]];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (cmd.start) state_nxt = B_SCAN;
      B_SCAN: if (dv_r && drow_r == ROW_W'(ROWS - 1)) state_nxt = B_FIN;
      B_FIN:  state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      issue_r <= '0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_IDLE && cmd.start) begin
        issue_r <= '0;
        dv_r    <= 1'b0;
      end else if (state_r == B_SCAN && issue_r < (ROW_W + 1)'(ROWS)) begin
        issue_r <= issue_r + 1'b1;
        dv_r    <= 1'b1;
      end else begin
        dv_r    <= 1'b0;
      end
    end
  end

  // scan accumulators
  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && cmd.start) begin
      kind_r     <= cmd.kind;
      slot_r     <= free_slot;
      ff_found_r <= 1'b0;
      free2_r    <= 1'b0;
      used1_r    <= 1'b0;
      used2_r    <= 1'b0;
      tgt_row_r  <= '0;
    end else if (state_r == B_SCAN && dv_r) begin
      if (!ff_found_r && f1) begin
        ff_found_r <= 1'b1;
        ff_slot_r  <= {drow_r, low_pos};
        ff_row_r   <= row_bits;
      end
      free2_r <= free2_r | f2 | (ff_found_r & f1);
      used2_r <= used2_r | u2 | (used1_r & u1);
      used1_r <= used1_r | u1;
      if (drow_r == slot_r[SLOT_W-1:BIT_W]) begin
        tgt_row_r <= row_bits;
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_row  = slot_r[SLOT_W-1:BIT_W];
    wr_data = tgt_row_r & ~(ROW_BITS'(1) << slot_r[BIT_W-1:0]);
    if (state_r == B_FIN) begin
      case (kind_r)
        BM_ALLOC: begin
          wr_en   = ff_found_r;
          wr_row  = ff_slot_r[SLOT_W-1:BIT_W];
          wr_data = ff_row_r | (ROW_BITS'(1) << ff_slot_r[BIT_W-1:0]);
        end
        BM_FREE: wr_en = tgt_set;
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_SCAN && issue_r < (ROW_W + 1)'(ROWS)) begin
      mem_q_r <= mem[issue_r[ROW_W-1:0]];
      vld_q_r <= row_valid_r[issue_r[ROW_W-1:0]];
      drow_r  <= issue_r[ROW_W-1:0];
    end
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[wr_row] <= 1'b1;
    end
  end

  // flags after the step
  always_comb begin
    rsp.done      = (state_r == B_FIN);
    rsp.found     = 1'b0;
    rsp.dbl       = 1'b0;
    rsp.has_space = ff_found_r;
    rsp.all_free  = !used1_r;
    case (kind_r)
      BM_ALLOC: begin
        rsp.found = ff_found_r;
        if (ff_found_r) begin
          rsp.has_space = free2_r;
          rsp.all_free  = 1'b0;
        end
      end
      BM_FREE: begin
        rsp.dbl = !tgt_set;
        if (tgt_set) begin
          rsp.has_space = 1'b1;
          rsp.all_free  = !used2_r;
        end
      end
      default: rsp.found = 1'b0;
    endcase
  end

  assign alloc_slot = ff_slot_r;

endmodule

@@ bench/tb_slab_page_bitmap_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slab_page_bitmap_allocator
// Self-checking bench for the slab page allocator. A scoreboard class keeps
// its own copy of the page registers and the occupancy bitmap, predicts the
// result of every accepted request and checks results in order. Stimulus is
// a short directed part, then random allocate/free/query traffic over
// several page layouts with random gaps on the request side and random
// stalls on the result side.
// ----------------------------------------------------------------------------
module tb_slab_page_bitmap_allocator;
  import slabpg_pkg::*;

  localparam int SLOTS = DEF_MAX_SLOTS;
  localparam int ITEMS_PER_PHASE = 167;

  typedef struct {
    status_t     status;
    logic [31:0] alloc_addr;
    logic        has_space;
    logic        all_free;
  } page_result_t;

  typedef struct {
    logic [31:0] base;
    logic [12:0] len;
    logic [12:0] size;
    logic [7:0]  count;
  } page_cfg_t;

  class page_scoreboard;
    bit            occupied[SLOTS];
    logic [31:0]   page_base;
    logic [12:0]   page_length;
    logic [12:0]   object_size;
    logic [7:0]    object_count;
    page_result_t  pending_results[$];
    int            mismatches;

    function new();
      page_base    = '0;
      page_length  = RST_PAGE_LENGTH;
      object_size  = RST_OBJECT_SIZE;
      object_count = RST_OBJECT_COUNT;
      foreach (occupied[i]) occupied[i] = 0;
      mismatches = 0;
    endfunction

    function int slot_limit();
      return (object_count < SLOTS) ? int'(object_count) : SLOTS;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] value);
      case (idx)
        REG_PAGE_BASE:    page_base    = value;
        REG_PAGE_LENGTH:  page_length  = value[12:0];
        REG_OBJECT_SIZE:  object_size  = value[12:0];
        REG_OBJECT_COUNT: object_count = value[7:0];
        default: ;
      endcase
    endfunction

    // random slot that currently holds an object, -1 if none
    function int random_used_slot();
      int used[$];
      for (int i = 0; i < slot_limit(); i++)
        if (occupied[i]) used.push_back(i);
      if (used.size() == 0) return -1;
      return used[$urandom_range(0, used.size() - 1)];
    endfunction

    function void apply_request(logic [1:0] op, logic [31:0] addr);
      page_result_t res;
      int           lim;
      int           slot;
      bit           ok;
      bit [63:0]    page_end;
      bit [63:0]    offset;
      bit [63:0]    sum;
      lim            = slot_limit();
      res.status     = ST_OK;
      res.alloc_addr = '0;
      case (op)
        OP_ALLOC: begin
          slot = 0;
          while (slot < lim && occupied[slot]) slot++;
          if (slot < lim) begin
            occupied[slot] = 1;
            sum = 64'(page_base) + 64'(slot) * 64'(object_size);
            res.alloc_addr = sum[31:0];
          end else begin
            res.status = ST_NOSPACE;
          end
        end
        OP_FREE: begin
          page_end = 64'(page_base) + 64'(page_length);
          ok = (64'(addr) >= 64'(page_base)) && (64'(addr) < page_end) && (object_size != 0);
          offset = ok ? 64'(addr) - 64'(page_base) : 64'd0;
          if (ok && (offset >= 64'(OFFSET_LIMIT) || offset % 64'(object_size) != 0))
            ok = 0;
          slot = 0;
          if (ok) begin
            offset = offset / 64'(object_size);
            if (offset >= 64'(lim)) ok = 0;
            else slot = int'(offset);
          end
          if (!ok) res.status = ST_BADADDR;
          else if (!occupied[slot]) res.status = ST_DOUBLE;
          else occupied[slot] = 0;
        end
        default: ;  // query, and the unused op code behaves as one
      endcase
      res.has_space = 0;
      res.all_free  = 1;
      for (int i = 0; i < lim; i++) begin
        if (occupied[i]) res.all_free = 0;
        else res.has_space = 1;
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [31:0] tdata, logic [3:0] tuser);
      page_result_t want;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing pending: tdata %h tuser %h", $realtime, tdata, tuser);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (tuser[1:0] !== want.status || tdata !== want.alloc_addr ||
          tuser[2] !== want.has_space || tuser[3] !== want.all_free) begin
        if (mismatches < 10)
          $display("%0t: mismatch: status %0d/%0d addr %h/%h has_space %b/%b all_free %b/%b",
                   $realtime, want.status, tuser[1:0], want.alloc_addr, tdata,
                   want.has_space, tuser[2], want.all_free, tuser[3]);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;
  logic [1:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic [3:0]           out_tuser;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = '0;
  logic [31:0]          cfg_wdata  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  page_scoreboard sb = new();

  page_cfg_t plan[9] = '{
    '{32'h1000_0000, 13'd4096, 13'd32,   8'd128},
    '{32'hFFFF_F000, 13'd4096, 13'd64,   8'd64},
    '{32'hFFFF_FF00, 13'd8191, 13'd16,   8'd200},
    '{32'hFFFF_FFFF, 13'd1,    13'd1,    8'd1},
    '{32'h0000_0100, 13'd8191, 13'd4096, 8'd2},
    '{32'hABCD_0000, 13'd0,    13'd0,    8'd16},
    '{32'h0000_0000, 13'd4096, 13'd24,   8'd170},
    '{32'h0000_0000, 13'd4096, 13'd24,   8'd10},   // count lowered under live bits
    '{32'h8000_0003, 13'd300,  13'd3,    8'd255}
  };

  slab_page_bitmap_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: check on handshake, then pick next ready at random
  always @(posedge clk) begin
    if (out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_request(logic [1:0] op, logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.apply_request(op, addr);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // leaves cfg_we high; program_page lowers it once after the last write
  task automatic cfg_write_reg(cfg_reg_t idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic program_page(page_cfg_t c);
    cfg_write_reg(REG_PAGE_BASE,    c.base);
    cfg_write_reg(REG_PAGE_LENGTH,  32'(c.len));
    cfg_write_reg(REG_OBJECT_SIZE,  32'(c.size));
    cfg_write_reg(REG_OBJECT_COUNT, 32'(c.count));
    cfg_we <= 1'b0;
  endtask

  function automatic void pick_request(output logic [1:0] op, output logic [31:0] addr);
    int r;
    int lim;
    int slot;
    r    = $urandom_range(99);
    lim  = sb.slot_limit();
    addr = $urandom;
    op   = OP_FREE;
    if (r < 42) begin
      op = OP_ALLOC;
    end else if (r < 62) begin
      slot = sb.random_used_slot();
      if (slot < 0) slot = $urandom_range(0, lim);
      addr = sb.page_base + slot * sb.object_size;
    end else if (r < 80) begin
      slot = $urandom_range(0, lim + 2);
      addr = sb.page_base + slot * sb.object_size;
    end else if (r < 88) begin
      addr = sb.page_base + $urandom_range(0, 4200);
    end else if (r < 93) begin
      ;  // fully random address
    end else if (r < 97) begin
      op = OP_QUERY;
    end else begin
      op = 2'd3;
    end
  endfunction

  initial begin
    logic [1:0]  op;
    logic [31:0] addr;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset layout: base 0, 32-byte objects, 128 slots
    send_request(OP_QUERY, 32'h0);
    send_request(2'd3,     32'hFFFF_FFFF);
    send_request(OP_FREE,  32'h0);           // slot never allocated
    send_request(OP_ALLOC, 32'h0);
    send_request(OP_ALLOC, 32'h0);
    send_request(OP_FREE,  32'd32);
    send_request(OP_FREE,  32'd32);          // same slot again
    send_request(OP_FREE,  32'd16);          // misaligned
    send_request(OP_FREE,  32'd4096);        // just past the page
    send_request(OP_FREE,  32'hFFFF_FFFF);
    send_request(OP_FREE,  32'd4064);        // last slot, free
    send_request(OP_ALLOC, 32'h0);
    send_request(OP_FREE,  32'h0);
    send_request(OP_FREE,  32'd32);
    drain_results();

    // page at the top of the address space: third allocation wraps to 0
    program_page('{32'hFFFF_FFC0, 13'd4096, 13'd32, 8'd3});
    repeat (4) send_request(OP_ALLOC, 32'h0);
    send_request(OP_FREE, 32'hFFFF_FFE0);
    send_request(OP_FREE, 32'h0);
    drain_results();

    // no slots and zero object size
    program_page('{32'h0000_0100, 13'd8191, 13'd0, 8'd0});
    send_request(OP_ALLOC, 32'h0);
    send_request(OP_FREE,  32'h0000_0100);
    drain_results();

    // count beyond the bitmap, zero size: every allocation lands on base
    program_page('{32'h0000_0100, 13'd8191, 13'd0, 8'd255});
    send_request(OP_ALLOC, 32'h0);
    send_request(OP_ALLOC, 32'h0);
    drain_results();

    foreach (plan[p]) begin
      program_page(plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        pick_request(op, addr);
        send_request(op, addr);
      end
      drain_results();
    end

    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/slabpg_pkg.sv
rtl/slabpg_div.sv
rtl/slabpg_bitmap.sv
rtl/slab_page_bitmap_allocator.sv
bench/tb_slab_page_bitmap_allocator.sv
